FILE: rtl/core/kct_pkg.sv
// shared types, constants and helpers for the keyed notification cooldown table
package kct_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int USER_W   = 64;
	localparam int OBJ_W    = 64;
	localparam int CLS_W    = 3;
	localparam int TIME_W   = 32;
	localparam int OP_W     = 2;
	localparam int CFG_W    = 16;
	localparam int NUM_CFG  = 6;
	localparam int CFG_IDX_W = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTIFY = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	// entity class codes
	localparam logic [1:0] ENT_CHARACTER = 2'd0;
	localparam logic [1:0] ENT_CREATURE  = 2'd1;
	localparam logic [1:0] ENT_STRUCTURE = 2'd2;
	localparam logic [1:0] ENT_UNUSED    = 2'd3;

	// interval register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AP_CHARACTER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AP_CREATURE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AP_STRUCTURE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORP_CHARACTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORP_CREATURE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORP_STRUCTURE = 3'd5;

	localparam logic [TIME_W-1:0] SWEEP_PERIOD = 32'd600;

	typedef logic [NUM_CFG-1:0][CFG_W-1:0] intervals_t;

	typedef struct packed {
		logic              valid;
		logic [USER_W-1:0] user;
		logic [CLS_W-1:0]  cls;
		logic [OBJ_W-1:0]  obj;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic              go;
		logic [OP_W-1:0]   op;
		logic              sweep;
		logic [USER_W-1:0] user;
		logic [CLS_W-1:0]  cls;
		logic [OBJ_W-1:0]  obj;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic allowed;
		logic full;
	} sts_t;

	// class code is protection bit on top of the entity code
	function automatic logic [CFG_W-1:0] class_interval(logic [CLS_W-1:0] cls, intervals_t iv);
		logic [CFG_IDX_W-1:0] idx;
		idx = cls[2] ? (CFG_IDX_W'(cls[1:0]) + REG_ORP_CHARACTER) : CFG_IDX_W'(cls[1:0]);
		if (cls[1:0] == ENT_UNUSED) begin
			return '0;
		end
		return iv[idx];
	endfunction

endpackage

FILE: rtl/core/kct_engine.sv
// entry memory with clearing pass, sequential scan and read-modify-write
module kct_engine #(
	parameter int TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kct_pkg::cmd_t      cmd,
	input  kct_pkg::intervals_t intervals,
	output kct_pkg::sts_t      sts
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	kct_pkg::entry_t  rd_word_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [kct_pkg::TIME_W-1:0] hit_stamp_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	kct_pkg::entry_t  mem_q [TABLE_ENTRIES];

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	kct_pkg::entry_t  wr_data;
	kct_pkg::entry_t  new_word;
	logic             s1_match;
	logic             s1_free;
	logic             s1_expired;
	logic             hit_expired;
	logic [kct_pkg::TIME_W-1:0] s1_age;
	logic [kct_pkg::TIME_W-1:0] hit_age;
	logic             op_query;
	logic             op_notify;
	logic             op_tick;
	logic             need_scan;

	assign op_query  = (cmd.op == kct_pkg::OP_QUERY);
	assign op_notify = (cmd.op == kct_pkg::OP_NOTIFY);
	assign op_tick   = (cmd.op == kct_pkg::OP_TICK);
	assign need_scan = op_query || op_notify || (op_tick && cmd.sweep);

	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q != CNT_END);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	assign s1_match = rd_vld_s1 && rd_word_s1.valid && (rd_word_s1.user == cmd.user) &&
		(rd_word_s1.cls == cmd.cls) && (rd_word_s1.obj == cmd.obj);
	assign s1_free  = rd_vld_s1 && !rd_word_s1.valid;
	assign s1_age   = cmd.now - rd_word_s1.stamp;
	assign s1_expired = s1_age >
		kct_pkg::TIME_W'(kct_pkg::class_interval(rd_word_s1.cls, intervals));

	assign hit_age = cmd.now - hit_stamp_q;
	assign hit_expired = hit_age >
		kct_pkg::TIME_W'(kct_pkg::class_interval(cmd.cls, intervals));

	always_comb begin
		new_word.valid = 1'b1;
		new_word.user  = cmd.user;
		new_word.cls   = cmd.cls;
		new_word.obj   = cmd.obj;
		new_word.stamp = cmd.now;
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = rd_idx_s1;
		wr_data = rd_word_s1;
		wr_data.valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = '0;
			end
			ST_SCAN: begin
				// sweep drops expired entries as they go by
				wr_en = op_tick && rd_vld_s1 && rd_word_s1.valid && s1_expired;
			end
			ST_FINISH: begin
				if (op_notify && hit_q) begin
					wr_en = 1'b1;
					wr_addr = hit_idx_q;
					wr_data = new_word;
				end else if (op_notify && free_q) begin
					wr_en = 1'b1;
					wr_addr = free_idx_q;
					wr_data = new_word;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem_q[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
		if (state_q == ST_SCAN && s1_match && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_stamp_q <= rd_word_s1.stamp;
		end
		if (state_q == ST_SCAN && s1_free && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			rd_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.go) begin
						hit_q <= 1'b0;
						free_q <= 1'b0;
						rd_cnt_q <= '0;
						state_q <= need_scan ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (s1_match) begin
						hit_q <= 1'b1;
					end
					if (s1_free) begin
						free_q <= 1'b1;
					end
					if (rd_cnt_q == CNT_END && rd_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sts.ready   = (state_q == ST_IDLE);
	assign sts.done    = (state_q == ST_FINISH);
	assign sts.allowed = (state_q == ST_FINISH) && op_query && (!hit_q || hit_expired);
	assign sts.full    = (state_q == ST_FINISH) && op_notify && !hit_q && !free_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("write and read hit the same entry");

	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> (state_q == ST_IDLE))
		else $error("command issued while engine not idle");

	a_finish_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (state_q == ST_IDLE))
		else $error("finish state held longer than one cycle");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("read data returned outside the scan");

endmodule

FILE: rtl/core/keyed_notification_cooldown_table.sv
// keyed notification cooldown table: top level with config registers and command port
//
// usage: an operation is accepted when start is high and busy is low; operation 0 queries,
// 1 records a notification, 2 is the periodic tick. exactly one result follows each
// transfer: done is high for a single cycle with allowed, table_full and swept valid
// in that cycle. the receiver cannot stall; the result is gone after that cycle.
// query, notify and a tick that sweeps read every entry of the table through one
// synchronous memory port, one entry per cycle; a new operation is taken at the edge
// that ends the done cycle. a tick that comes too early, and an unused operation code,
// skip the scan and go straight to the finish state. interval registers are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while no operation
// is in flight, the block itself does not enforce this; indexes beyond the last register
// are ignored. after reset the table memory is cleared one entry per cycle and busy
// stays high while it runs; intervals and the last sweep time reset to zero.
module keyed_notification_cooldown_table #(
	parameter int TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [kct_pkg::OP_W-1:0]        operation,
	input  logic [kct_pkg::USER_W-1:0]      user_id,
	input  logic                            protection_class,
	input  logic [1:0]                      entity_class,
	input  logic [kct_pkg::OBJ_W-1:0]       object_key,
	input  logic [kct_pkg::TIME_W-1:0]      now_seconds,
	input  logic                            cfg_write,
	input  logic [kct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kct_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output logic                            allowed,
	output logic                            table_full,
	output logic                            swept
);

	kct_pkg::intervals_t        intervals_q;
	kct_pkg::cmd_t              cmd_q;
	kct_pkg::sts_t              sts;
	logic [kct_pkg::TIME_W-1:0] last_sweep_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       allowed_q;
	logic                       full_q;
	logic                       swept_q;
	logic                       accept;
	logic                       sweep_due;

	assign accept = start && !busy;
	assign busy = busy_q || !sts.ready;
	assign sweep_due = (operation == kct_pkg::OP_TICK) &&
		((now_seconds - last_sweep_q) >= kct_pkg::SWEEP_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intervals_q <= '0;
		end else if (cfg_write && cfg_index <= kct_pkg::REG_ORP_STRUCTURE) begin
			intervals_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			busy_q <= 1'b0;
			last_sweep_q <= '0;
			done_q <= 1'b0;
			allowed_q <= 1'b0;
			full_q <= 1'b0;
			swept_q <= 1'b0;
		end else begin
			cmd_q.go <= accept;
			// command fields stay put while the engine works on them
			if (accept) begin
				cmd_q.op    <= operation;
				cmd_q.sweep <= sweep_due;
				cmd_q.user  <= user_id;
				cmd_q.cls   <= {protection_class, entity_class};
				cmd_q.obj   <= object_key;
				cmd_q.now   <= now_seconds;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (sts.done) begin
				busy_q <= 1'b0;
			end
			if (accept && sweep_due) begin
				last_sweep_q <= now_seconds;
			end
			done_q <= sts.done;
			allowed_q <= sts.done && sts.allowed;
			full_q <= sts.done && sts.full;
			swept_q <= sts.done && cmd_q.sweep;
		end
	end

	kct_engine #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_q),
		.intervals (intervals_q),
		.sts       (sts)
	);

	assign done = done_q;
	assign allowed = allowed_q;
	assign table_full = full_q;
	assign swept = swept_q;

endmodule

FILE: tb/keyed_notification_cooldown_table_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the keyed notification cooldown table
module keyed_notification_cooldown_table_tb;
	import kct_pkg::*;

	localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int POOL_MAX = 128;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [USER_W-1:0] user;
		logic              prot;
		logic [1:0]        ent;
		logic [OBJ_W-1:0]  obj;
		logic [TIME_W-1:0] now;
	} cooldown_cmd_t;

	typedef struct packed {
		logic allowed;
		logic table_full;
		logic swept;
	} cooldown_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [OP_W-1:0]      operation = '0;
	logic [USER_W-1:0]    user_id = '0;
	logic                 protection_class = 1'b0;
	logic [1:0]           entity_class = '0;
	logic [OBJ_W-1:0]     object_key = '0;
	logic [TIME_W-1:0]    now_seconds = '0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 done;
	logic                 allowed;
	logic                 table_full;
	logic                 swept;

	keyed_notification_cooldown_table #(
		.TABLE_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.user_id(user_id),
		.protection_class(protection_class),
		.entity_class(entity_class),
		.object_key(object_key),
		.now_seconds(now_seconds),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.allowed(allowed),
		.table_full(table_full),
		.swept(swept)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the cooldown table and interval registers
	logic [CFG_W-1:0]  iv_model [NUM_CFG];
	logic              tbl_valid [TABLE_DEPTH];
	logic [USER_W-1:0] tbl_user [TABLE_DEPTH];
	logic [CLS_W-1:0]  tbl_cls [TABLE_DEPTH];
	logic [OBJ_W-1:0]  tbl_obj [TABLE_DEPTH];
	logic [TIME_W-1:0] tbl_stamp [TABLE_DEPTH];
	logic [TIME_W-1:0] sweep_mark;

	cooldown_cmd_t    pending_cmds[$];
	cooldown_result_t expected_results[$];
	int               outstanding = 0;
	int               err_count = 0;
	int               sender_idle_pct = 0;

	// key pool for the random traffic
	logic [USER_W-1:0] key_user [POOL_MAX];
	logic [OBJ_W-1:0]  key_obj [POOL_MAX];
	logic              key_prot [POOL_MAX];
	logic [1:0]        key_ent [POOL_MAX];
	logic [TIME_W-1:0] clock_now;

	function automatic logic [CFG_W-1:0] cooldown_for(logic [CLS_W-1:0] cls);
		if (cls[1:0] == ENT_UNUSED) begin
			return '0;
		end
		return iv_model[(cls[2] ? int'(REG_ORP_CHARACTER) : 0) + int'(cls[1:0])];
	endfunction

	function automatic logic is_stale(int idx, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] age;
		age = now - tbl_stamp[idx];
		return age > TIME_W'(cooldown_for(tbl_cls[idx]));
	endfunction

	function automatic int lookup_entry(cooldown_cmd_t c);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_valid[i] && tbl_user[i] == c.user && tbl_cls[i] == {c.prot, c.ent} &&
					tbl_obj[i] == c.obj) begin
				return i;
			end
		end
		return -1;
	endfunction

	// updates the shadow table and returns the result the block should report
	function automatic cooldown_result_t apply_command(cooldown_cmd_t c);
		cooldown_result_t r;
		int hit;
		int slot;
		logic [TIME_W-1:0] since_sweep;
		r = '0;
		case (c.op)
			OP_QUERY: begin
				hit = lookup_entry(c);
				r.allowed = (hit < 0) ? 1'b1 : is_stale(hit, c.now);
			end
			OP_NOTIFY: begin
				hit = lookup_entry(c);
				if (hit >= 0) begin
					tbl_stamp[hit] = c.now;
				end else begin
					slot = -1;
					for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
						if (!tbl_valid[i]) begin
							slot = i;
						end
					end
					if (slot >= 0) begin
						tbl_valid[slot] = 1'b1;
						tbl_user[slot] = c.user;
						tbl_cls[slot] = {c.prot, c.ent};
						tbl_obj[slot] = c.obj;
						tbl_stamp[slot] = c.now;
					end else begin
						r.table_full = 1'b1;
					end
				end
			end
			OP_TICK: begin
				since_sweep = c.now - sweep_mark;
				if (since_sweep >= SWEEP_PERIOD) begin
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (tbl_valid[i] && is_stale(i, c.now)) begin
							tbl_valid[i] = 1'b0;
						end
					end
					sweep_mark = c.now;
					r.swept = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// command driver: raises start and holds it until the transfer
	always @(posedge clk) begin : command_driver
		cooldown_cmd_t nxt;
		if (arst_n && (!start || !busy)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = pending_cmds.pop_front();
				start <= 1'b1;
				operation <= nxt.op;
				user_id <= nxt.user;
				protection_class <= nxt.prot;
				entity_class <= nxt.ent;
				object_key <= nxt.obj;
				now_seconds <= nxt.now;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor: predicts on each command transfer, checks on each done strobe
	always @(posedge clk) begin : result_monitor
		cooldown_result_t want;
		cooldown_cmd_t seen;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing pending: allowed=%b table_full=%b swept=%b",
						$time, allowed, table_full, swept);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					outstanding--;
					if (allowed !== want.allowed) begin
						$display("%0t: allowed mismatch, expected %b, got %b",
							$time, want.allowed, allowed);
						err_count++;
					end
					if (table_full !== want.table_full) begin
						$display("%0t: table_full mismatch, expected %b, got %b",
							$time, want.table_full, table_full);
						err_count++;
					end
					if (swept !== want.swept) begin
						$display("%0t: swept mismatch, expected %b, got %b",
							$time, want.swept, swept);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				seen.op = operation;
				seen.user = user_id;
				seen.prot = protection_class;
				seen.ent = entity_class;
				seen.obj = object_key;
				seen.now = now_seconds;
				expected_results = {expected_results, apply_command(seen)};
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < NUM_CFG) begin
			iv_model[idx] = val;
		end
	endtask

	// also pokes the unused indexes, which must be ignored
	task automatic program_intervals(logic [CFG_W-1:0] ap_chr, logic [CFG_W-1:0] ap_cre,
			logic [CFG_W-1:0] ap_str, logic [CFG_W-1:0] orp_chr, logic [CFG_W-1:0] orp_cre,
			logic [CFG_W-1:0] orp_str);
		write_reg(REG_AP_CHARACTER, ap_chr);
		write_reg(REG_AP_CREATURE, ap_cre);
		write_reg(REG_AP_STRUCTURE, ap_str);
		write_reg(REG_ORP_CHARACTER, orp_chr);
		write_reg(REG_ORP_CREATURE, orp_cre);
		write_reg(REG_ORP_STRUCTURE, orp_str);
		write_reg(CFG_IDX_W'(NUM_CFG), CFG_W'($urandom));
		write_reg('1, CFG_W'($urandom));
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// waits until every queued command has produced its result and the block is idle
	task automatic settle();
		while (outstanding != 0 || busy) begin
			@(posedge clk);
		end
	endtask

	task automatic queue_cmd(logic [OP_W-1:0] op, logic [USER_W-1:0] user, logic prot,
			logic [1:0] ent, logic [OBJ_W-1:0] obj, logic [TIME_W-1:0] now);
		cooldown_cmd_t c;
		c.op = op;
		c.user = user;
		c.prot = prot;
		c.ent = ent;
		c.obj = obj;
		c.now = now;
		pending_cmds = {pending_cmds, c};
		outstanding++;
	endtask

	// mostly well-formed traffic on a pool of keys with time moving forward
	task automatic run_segment(int count, int pool_n, int pct_notify, int pct_query,
			int pct_tick, int step_max, int jump_pct);
		logic [USER_W-1:0] shared_users [4];
		cooldown_cmd_t c;
		int k;
		int roll;
		for (int i = 0; i < 4; i++) begin
			shared_users[i] = {$urandom, $urandom};
		end
		for (int i = 0; i < pool_n; i++) begin
			key_user[i] = $urandom_range(1) ? shared_users[$urandom_range(3)] : {$urandom, $urandom};
			key_obj[i] = {$urandom, $urandom};
			key_prot[i] = 1'($urandom_range(1));
			key_ent[i] = ($urandom_range(7) == 0) ? ENT_UNUSED : 2'($urandom_range(2));
		end
		clock_now = $urandom;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(pool_n - 1);
			roll = $urandom_range(99);
			c.user = key_user[k];
			c.obj = key_obj[k];
			c.prot = key_prot[k];
			c.ent = key_ent[k];
			if (roll < pct_notify) begin
				c.op = OP_NOTIFY;
			end else if (roll < pct_notify + pct_query) begin
				c.op = OP_QUERY;
			end else if (roll < pct_notify + pct_query + pct_tick) begin
				c.op = OP_TICK;
			end else begin
				c.op = OP_W'($urandom_range(3));
				c.user = {$urandom, $urandom};
				c.obj = {$urandom, $urandom};
				c.prot = 1'($urandom_range(1));
				c.ent = 2'($urandom_range(3));
			end
			clock_now += TIME_W'($urandom_range(step_max));
			if ($urandom_range(99) < jump_pct) begin
				clock_now += TIME_W'($urandom);
			end
			c.now = ($urandom_range(49) == 0) ? TIME_W'($urandom) : clock_now;
			queue_cmd(c.op, c.user, c.prot, c.ent, c.obj, c.now);
		end
		settle();
	endtask

	initial begin : stimulus
		logic [USER_W-1:0] user_a;
		logic [OBJ_W-1:0]  obj_a;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
		end
		for (int i = 0; i < NUM_CFG; i++) begin
			iv_model[i] = '0;
		end
		sweep_mark = '0;
		user_a = 64'h0123_4567_89ab_cdef;
		obj_a = 64'hfedc_ba98_7654_3210;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settle();

		// directed part
		sender_idle_pct = 38;
		program_intervals(16'd10, 16'd0, 16'hffff, 16'd100, 16'd1, 16'd30000);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd5);
		queue_cmd(OP_NOTIFY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd5);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd15);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd16);
		queue_cmd(OP_TICK, '0, 1'b0, ENT_CHARACTER, '0, 32'd599);
		queue_cmd(OP_NOTIFY, '1, 1'b1, ENT_STRUCTURE, '1, 32'd100);
		queue_cmd(OP_NOTIFY, user_a, 1'b0, ENT_UNUSED, '0, 32'd100);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_UNUSED, '0, 32'd100);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_UNUSED, '0, 32'd101);
		queue_cmd(OP_NOTIFY, '0, 1'b1, ENT_CREATURE, '0, 32'd200);
		queue_cmd(OP_NOTIFY, '0, 1'b0, ENT_CREATURE, '0, 32'd200);
		queue_cmd(OP_TICK, '1, 1'b1, ENT_UNUSED, '1, 32'd600);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd601);
		queue_cmd(OP_QUERY, '1, 1'b1, ENT_STRUCTURE, '1, 32'd601);
		queue_cmd(OP_NOTIFY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'hffff_fff8);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd2);
		queue_cmd(OP_QUERY, user_a, 1'b0, ENT_CHARACTER, obj_a, 32'd3);
		queue_cmd(OP_UNUSED, '1, 1'b1, ENT_UNUSED, '1, '1);
		queue_cmd(OP_NOTIFY, '1, 1'b1, ENT_STRUCTURE, '1, '1);
		queue_cmd(OP_QUERY, '1, 1'b0, ENT_STRUCTURE, '1, '1);
		queue_cmd(OP_TICK, '0, 1'b0, ENT_CHARACTER, '0, '1);
		queue_cmd(OP_TICK, '0, 1'b0, ENT_CHARACTER, '0, 32'd3);
		queue_cmd(OP_QUERY, '1, 1'b1, ENT_STRUCTURE, '1, 32'd3);
		settle();

		// random part, several interval settings
		program_intervals(CFG_W'($urandom_range(200)), CFG_W'($urandom_range(200)),
			CFG_W'($urandom_range(200)), CFG_W'($urandom_range(200)),
			CFG_W'($urandom_range(200)), CFG_W'($urandom_range(200)));
		run_segment(110, 12, 40, 40, 15, 60, 3);

		// long cooldowns and many distinct keys so the table fills up
		program_intervals('1, '1, '1, '1, '1, '1);
		run_segment(150, 100, 85, 10, 3, 2, 0);

		sender_idle_pct = 85;
		program_intervals('0, '0, '0, '0, '0, '0);
		run_segment(100, 20, 35, 45, 15, 3, 2);

		program_intervals(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
		run_segment(110, 30, 40, 40, 15, 20000, 5);

		sender_idle_pct = 0;
		program_intervals('0, '1, 16'd1, 16'hfffe, 16'd600, 16'd0);
		run_segment(120, 16, 40, 40, 15, 100, 3);

		program_intervals(CFG_W'($urandom_range(50)), CFG_W'($urandom_range(50)),
			CFG_W'($urandom_range(50)), CFG_W'($urandom_range(50)),
			CFG_W'($urandom_range(50)), CFG_W'($urandom_range(50)));
		run_segment(110, 70, 60, 30, 7, 10, 2);

		// let any stray strobe show up before the verdict
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
